### src/lnp_pkg.sv
// lnp_pkg: shared constants, types and helpers of the lif neuron core
// with exponential-current synapse rings; no dependencies
package lnp_pkg;

    // population and ring geometry
    localparam int POP_SIZE = 128;
    localparam int SLOTS    = 16;

    localparam int NEUR_AW   = (POP_SIZE > 1) ? $clog2(POP_SIZE) : 1;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int BIN_DEPTH = POP_SIZE * SLOTS;
    localparam int BIN_AW    = $clog2(BIN_DEPTH);

    // fixed field layout
    localparam int DATA_W     = 32;
    localparam int REFR_W     = 16;
    localparam int DECAY_W    = 17;
    localparam int IDX_W      = 7;
    localparam int WEIGHT_W   = 24;
    localparam int TYPE_BIT   = 24;
    localparam int TARGET_LSB = 25;
    localparam int TARGET_W   = 7;
    localparam int FRAC_BITS  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int NEUR_W     = DATA_W + REFR_W;

    // shared multiplier: 33-bit signed by 18-bit signed
    localparam int MUL_A_W = DATA_W + 1;
    localparam int MUL_B_W = DECAY_W + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef enum logic [1:0] {
        CMD_SYN  = 2'd0,
        CMD_UPD  = 2'd1,
        CMD_TICK = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REST   = 3'd0,
        CFG_MDECAY = 3'd1,
        CFG_BIAS   = 3'd2,
        CFG_THRESH = 3'd3,
        CFG_VRESET = 3'd4,
        CFG_REFR   = 3'd5,
        CFG_EDECAY = 3'd6,
        CFG_IDECAY = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [DATA_W-1:0]  rest;
        logic [DECAY_W-1:0] mdecay;
        logic [DATA_W-1:0]  bias;
        logic [DATA_W-1:0]  thresh;
        logic [DATA_W-1:0]  vreset;
        logic [REFR_W-1:0]  refr_ticks;
        logic [DECAY_W-1:0] edecay;
        logic [DECAY_W-1:0] idecay;
    } t_cfg;

    // bin address of one neuron's ring entry
    function automatic logic [BIN_AW-1:0] bin_addr(input logic [NEUR_AW-1:0] nid,
                                                   input logic [SLOT_W-1:0] slot);
        bin_addr = BIN_AW'(int'(nid) * SLOTS + int'(slot));
    endfunction

endpackage

### src/lnp_ram.sv
// lnp_ram: generic single-write, single-read memory with registered read data
// no dependencies
module lnp_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/lnp_mul.sv
// lnp_mul: shared registered signed multiplier for membrane and current decay
// depends on lnp_pkg
module lnp_mul (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [lnp_pkg::MUL_A_W-1:0] i_a,
    input  logic signed [lnp_pkg::MUL_B_W-1:0] i_b,
    output logic signed [lnp_pkg::MUL_P_W-1:0] o_p
);

    logic signed [lnp_pkg::MUL_P_W-1:0] r_p;

    // product holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

### src/lnp_cfg.sv
// lnp_cfg: shared neuron parameter registers written over the config channel
// depends on lnp_pkg
module lnp_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_we,
    input  logic [lnp_pkg::CFG_IDX_W-1:0]    i_index,
    input  logic [lnp_pkg::DATA_W-1:0]       i_data,
    output lnp_pkg::t_cfg                    o_cfg
);

    lnp_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_we) begin
            unique case (lnp_pkg::t_cfg_idx'(i_index))
                lnp_pkg::CFG_REST:   r_cfg.rest       <= i_data;
                lnp_pkg::CFG_MDECAY: r_cfg.mdecay     <= i_data[lnp_pkg::DECAY_W-1:0];
                lnp_pkg::CFG_BIAS:   r_cfg.bias       <= i_data;
                lnp_pkg::CFG_THRESH: r_cfg.thresh     <= i_data;
                lnp_pkg::CFG_VRESET: r_cfg.vreset     <= i_data;
                lnp_pkg::CFG_REFR:   r_cfg.refr_ticks <= i_data[lnp_pkg::REFR_W-1:0];
                lnp_pkg::CFG_EDECAY: r_cfg.edecay     <= i_data[lnp_pkg::DECAY_W-1:0];
                lnp_pkg::CFG_IDECAY: r_cfg.idecay     <= i_data[lnp_pkg::DECAY_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### src/lif_neuron_core_psp_ring_core.sv
// lif_neuron_core_psp_ring_core: lif neuron population with excitatory and
// inhibitory input rings; depends on lnp_pkg, lnp_ram, lnp_mul, lnp_cfg
//
//  channel   direction  handshake               payload
//  input     in         i_in_valid/o_in_stall   i_cmd i_synapse_word i_neuron_index i_row_last
//  result    out        o_out_valid/i_out_stall o_out_neuron o_spike o_membrane o_net_current
//  config    in         i_cfg_valid/o_cfg_ready i_cfg_index i_cfg_data
//
// a tick or dropped beat is handled in the idle state, a synapse beat reads and rewrites one bin;
// a neuron update does a read, two sums, three passes through the shared multiplier and
// three bin/neuron writes; after reset a clearing pass over all POP_SIZE*SLOTS (2048) bin
// addresses zeroes all stores while o_in_stall is high; config writes are taken at any time
// the result register lets the next beat in while a result waits; an update
// completes only once the result register is free
module lif_neuron_core_psp_ring_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_cmd,
    input  logic [lnp_pkg::DATA_W-1:0]      i_synapse_word,
    input  logic [lnp_pkg::IDX_W-1:0]       i_neuron_index,
    input  logic                            i_row_last,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [lnp_pkg::IDX_W-1:0]       o_out_neuron,
    output logic                            o_spike,
    output logic [lnp_pkg::DATA_W-1:0]      o_membrane,
    output logic [lnp_pkg::DATA_W-1:0]      o_net_current,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lnp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lnp_pkg::DATA_W-1:0]      i_cfg_data
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_SYN, S_SUM, S_DIFF,
        S_MUL_V, S_MUL_E, S_FIRE, S_WR_E, S_WR_I
    } t_state;

    localparam int DW = lnp_pkg::DATA_W;
    localparam int FB = lnp_pkg::FRAC_BITS;

    t_state r_state;
    logic [lnp_pkg::BIN_AW-1:0]   r_clr;
    logic [lnp_pkg::SLOT_W-1:0]   r_slot;
    logic                         r_upd;
    logic                         r_inh_sel;
    logic [lnp_pkg::NEUR_AW-1:0]  r_nid;
    logic [lnp_pkg::WEIGHT_W-1:0] r_weight;
    logic [DW-1:0]                r_exc, r_inh, r_v, r_cur, r_rv, r_diff, r_v1, r_vout;
    logic [DW-1:0]                r_exc_new, r_inh_new;
    logic [lnp_pkg::REFR_W-1:0]   r_refr, r_refr_new;
    logic                         r_spike;
    logic                         r_out_valid;
    logic [lnp_pkg::IDX_W-1:0]    r_out_neuron;
    logic                         r_out_spike;
    logic [DW-1:0]                r_out_mem, r_out_cur;

    lnp_pkg::t_cfg cfg;
    logic [lnp_pkg::SLOT_W-1:0]   nxt_slot;
    logic [lnp_pkg::BIN_AW-1:0]   cur_addr, nxt_addr, bin_raddr;
    logic                         in_acc, out_free;
    logic                         n_spike;
    logic [DW-1:0]                step;
    logic [lnp_pkg::TARGET_W-1:0] target;

    logic                         e_we, ib_we, n_we;
    logic [lnp_pkg::BIN_AW-1:0]   e_waddr, ib_waddr;
    logic [DW-1:0]                e_wdata, ib_wdata, e_rdata, ib_rdata;
    logic [lnp_pkg::NEUR_AW-1:0]  n_waddr;
    logic [lnp_pkg::NEUR_W-1:0]   n_wdata, n_rdata;

    logic                                mul_en;
    logic signed [lnp_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [lnp_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [lnp_pkg::MUL_P_W-1:0]  mul_p;

    lnp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    lnp_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    lnp_ram #(.DEPTH(lnp_pkg::BIN_DEPTH), .WIDTH(DW)) u_exc_bins (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_raddr (bin_raddr),
        .o_rdata (e_rdata)
    );

    lnp_ram #(.DEPTH(lnp_pkg::BIN_DEPTH), .WIDTH(DW)) u_inh_bins (
        .i_clk   (i_clk),
        .i_we    (ib_we),
        .i_waddr (ib_waddr),
        .i_wdata (ib_wdata),
        .i_raddr (bin_raddr),
        .o_rdata (ib_rdata)
    );

    // membrane in the upper word, refractory count in the lower
    lnp_ram #(.DEPTH(lnp_pkg::POP_SIZE), .WIDTH(lnp_pkg::NEUR_W)) u_neurons (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (n_waddr),
        .i_wdata (n_wdata),
        .i_raddr (r_nid),
        .o_rdata (n_rdata)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign target   = i_synapse_word[lnp_pkg::TARGET_LSB +: lnp_pkg::TARGET_W];
    assign nxt_slot = (r_slot == lnp_pkg::SLOT_W'(lnp_pkg::SLOTS - 1)) ?
                      '0 : r_slot + 1'b1;
    assign cur_addr  = lnp_pkg::bin_addr(r_nid, r_slot);
    assign nxt_addr  = lnp_pkg::bin_addr(r_nid, nxt_slot);
    assign bin_raddr = (r_state == S_READ && r_upd) ? cur_addr : nxt_addr;

    // floor shift of the product, kept to 32 bits
    assign step    = mul_p[FB+DW-1:FB];
    assign n_spike = ($signed(r_v1) >= $signed(cfg.thresh));

    // operand select for the shared multiplier
    always_comb begin
        mul_en = 1'b0;
        mul_a  = $signed({1'b0, r_inh});
        mul_b  = $signed({1'b0, cfg.idecay});
        case (r_state)
            S_MUL_V: begin
                mul_en = 1'b1;
                mul_a  = $signed({r_diff[DW-1], r_diff});
                mul_b  = $signed({1'b0, cfg.mdecay});
            end
            S_MUL_E: begin
                mul_en = 1'b1;
                mul_a  = $signed({1'b0, r_exc});
                mul_b  = $signed({1'b0, cfg.edecay});
            end
            S_FIRE: begin
                mul_en = 1'b1;
            end
            default: ;
        endcase
    end

    // memory write ports
    always_comb begin
        e_we     = 1'b0;
        e_waddr  = nxt_addr;
        e_wdata  = '0;
        ib_we    = 1'b0;
        ib_waddr = nxt_addr;
        ib_wdata = '0;
        n_we     = 1'b0;
        n_waddr  = r_nid;
        n_wdata  = {r_vout, r_refr_new};
        case (r_state)
            S_CLEAR: begin
                e_we     = 1'b1;
                e_waddr  = r_clr;
                ib_we    = 1'b1;
                ib_waddr = r_clr;
                n_we     = (int'(r_clr) < lnp_pkg::POP_SIZE);
                n_waddr  = r_clr[lnp_pkg::NEUR_AW-1:0];
                n_wdata  = '0;
            end
            S_SYN: begin
                e_we     = !r_inh_sel;
                e_wdata  = e_rdata + DW'(r_weight);
                ib_we    = r_inh_sel;
                ib_wdata = ib_rdata + DW'(r_weight);
            end
            S_FIRE: begin
                // current slot bins are consumed
                e_we     = 1'b1;
                e_waddr  = cur_addr;
                ib_we    = 1'b1;
                ib_waddr = cur_addr;
            end
            S_WR_E: begin
                e_we    = 1'b1;
                e_wdata = r_exc_new;
                n_we    = 1'b1;
            end
            S_WR_I: begin
                ib_we    = out_free;
                ib_wdata = r_inh_new;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // the last update state reloads the result register itself
            if (r_out_valid && !i_out_stall && r_state != S_WR_I) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == lnp_pkg::BIN_AW'(lnp_pkg::BIN_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_cmd)
                            lnp_pkg::CMD_SYN: begin
                                r_upd     <= 1'b0;
                                r_nid     <= lnp_pkg::NEUR_AW'(target);
                                r_inh_sel <= i_synapse_word[lnp_pkg::TYPE_BIT];
                                r_weight  <= i_synapse_word[lnp_pkg::WEIGHT_W-1:0];
                                if (int'(target) < lnp_pkg::POP_SIZE) begin
                                    r_state <= S_READ;
                                end
                            end
                            lnp_pkg::CMD_UPD: begin
                                r_upd <= 1'b1;
                                r_nid <= lnp_pkg::NEUR_AW'(i_neuron_index);
                                if (int'(i_neuron_index) < lnp_pkg::POP_SIZE) begin
                                    r_state <= S_READ;
                                end
                            end
                            lnp_pkg::CMD_TICK: begin
                                r_slot <= nxt_slot;
                            end
                            default: ;
                        endcase
                    end
                end
                S_READ: begin
                    r_state <= r_upd ? S_SUM : S_SYN;
                end
                S_SYN: begin
                    r_state <= S_IDLE;
                end
                S_SUM: begin
                    r_exc   <= e_rdata;
                    r_inh   <= ib_rdata;
                    r_v     <= n_rdata[lnp_pkg::NEUR_W-1:lnp_pkg::REFR_W];
                    r_refr  <= n_rdata[lnp_pkg::REFR_W-1:0];
                    r_cur   <= e_rdata - ib_rdata + cfg.bias;
                    r_rv    <= cfg.rest - n_rdata[lnp_pkg::NEUR_W-1:lnp_pkg::REFR_W];
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_diff  <= r_rv + r_cur;
                    r_state <= S_MUL_V;
                end
                S_MUL_V: begin
                    r_state <= S_MUL_E;
                end
                S_MUL_E: begin
                    // refractory neurons keep their membrane
                    r_v1    <= (r_refr == '0) ? r_v + step : r_v;
                    r_state <= S_FIRE;
                end
                S_FIRE: begin
                    r_spike <= n_spike;
                    if (n_spike) begin
                        r_vout     <= cfg.vreset + r_v1 - cfg.thresh;
                        r_refr_new <= cfg.refr_ticks;
                    end else begin
                        r_vout     <= r_v1;
                        r_refr_new <= (r_refr != '0) ? r_refr - 1'b1 : r_refr;
                    end
                    // next-slot bin read is still on the port
                    r_exc_new <= e_rdata + r_exc - step;
                    r_state   <= S_WR_E;
                end
                S_WR_E: begin
                    r_inh_new <= ib_rdata + r_inh - step;
                    r_state   <= S_WR_I;
                end
                S_WR_I: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_neuron <= lnp_pkg::IDX_W'(r_nid);
                        r_out_spike  <= r_spike;
                        r_out_mem    <= r_vout;
                        r_out_cur    <= (r_refr == '0) ? r_cur : '0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_neuron  = r_out_neuron;
    assign o_spike       = r_out_spike;
    assign o_membrane    = r_out_mem;
    assign o_net_current = r_out_cur;

endmodule

### src/lnp_chk.sv
// lnp_chk: port-level checks of the lif neuron core, bound to the top level
// depends on lnp_pkg and lif_neuron_core_psp_ring_core
module lnp_chk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            o_in_stall,
    input  logic [1:0]                      i_cmd,
    input  logic [lnp_pkg::IDX_W-1:0]       i_neuron_index,
    input  logic                            o_out_valid,
    input  logic                            i_out_stall,
    input  logic [lnp_pkg::IDX_W-1:0]       o_out_neuron,
    input  logic                            o_spike,
    input  logic [lnp_pkg::DATA_W-1:0]      o_membrane,
    input  logic [lnp_pkg::DATA_W-1:0]      o_net_current
);

    logic in_beat;
    assign in_beat = i_in_valid && !o_in_stall;

    // result beat held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_neuron) && $stable(o_spike) &&
            $stable(o_membrane) && $stable(o_net_current))
        else $error("result beat changed while stalled");

    // reset starts the clearing pass with no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall && !o_out_valid)
        else $error("block not clearing after reset");

    // a valid neuron update occupies the block
    a_upd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && i_cmd == lnp_pkg::CMD_UPD &&
        int'(i_neuron_index) < lnp_pkg::POP_SIZE |=> o_in_stall)
        else $error("update beat did not occupy the block");

    // a tick completes in its own cycle
    a_tick_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && i_cmd == lnp_pkg::CMD_TICK |=> !o_in_stall)
        else $error("tick beat left the block busy");

endmodule

bind lif_neuron_core_psp_ring_core lnp_chk u_lnp_chk (.*);
